// ===== rtl/core/zpg_pkg.sv =====
// ----------------------------------------------------------------------------
// zpg_pkg
// Shared types, constants and elaboration-time tables for the zone-plate
// pixel generator.
// ----------------------------------------------------------------------------
package zpg_pkg;

	localparam int SUB_ORDER = 5;
	localparam int GRID      = 2 * SUB_ORDER - 1;
	localparam int GRID_W    = $clog2(GRID);
	localparam int MAX_SIDE  = 4096;
	localparam int SINE_BITS = 10;
	localparam int TURN_BITS = 40;
	localparam int QTR_N     = 2 ** (SINE_BITS - 2);
	localparam int QTR_W     = SINE_BITS - 2;
	localparam int N4        = 4 * SUB_ORDER;

	localparam int COORD_W = 17;
	localparam int OFF_W   = 5;
	localparam int WT_W    = 18;
	localparam int MAG_W   = 15;
	localparam int F_W     = 16;
	localparam int FW1_W   = F_W + WT_W;
	localparam int FW_W    = FW1_W + WT_W;
	localparam int ACC_W   = FW_W + 7;
	localparam int SUMW_W  = 40;
	localparam int DIV_W   = 56;
	localparam int Q_W     = 16;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;
	localparam int IN_DEPTH  = 2;

	localparam logic [63:0] TWO_PI_Q30     = 64'd6746518852;
	localparam logic [31:0] HALF_SCALE_Q32 = 32'd2147483219;

	localparam logic [1:0] REG_WIDTH      = 2'd0;
	localparam logic [1:0] REG_HEIGHT     = 2'd1;
	localparam logic [1:0] REG_MAX_GRAY   = 2'd2;
	localparam logic [1:0] REG_PHASE_STEP = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} pix_t;

	typedef struct packed {
		logic                    vld;
		logic signed [ACC_W-1:0] sum;
	} acc_t;

	typedef logic [QTR_N-1:0][MAG_W-1:0] sine_tab_t;
	typedef logic [GRID-1:0][WT_W-1:0] wt_tab_t;
	typedef logic [GRID-1:0][OFF_W-1:0] off_tab_t;

	function automatic longint sine_q30(longint unsigned t);
		longint unsigned quad;
		longint unsigned quarter;
		longint unsigned r;
		longint unsigned x;
		longint unsigned term;
		longint s;
		quad = (t >> (TURN_BITS - 2)) & 64'd3;
		quarter = 64'd1 << (TURN_BITS - 2);
		r = t & (quarter - 64'd1);
		if (quad[0]) begin
			r = quarter - r;
		end
		x = ((r >> 10) * TWO_PI_Q30) >> 30;
		term = x;
		s = longint'(x);
		for (int k = 1; k <= 5; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			case (k)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				default: term = term / 64'd110;
			endcase
			if (k % 2 == 1) begin
				s = s - longint'(term);
			end else begin
				s = s + longint'(term);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		if (s > (longint'(1) << 30)) begin
			s = longint'(1) << 30;
		end
		return quad[1] ? -s : s;
	endfunction

	function automatic logic [MAG_W-1:0] sine_mag(int k);
		longint s;
		longint v;
		s = sine_q30(longint'(k) << (TURN_BITS - SINE_BITS));
		v = (s + (longint'(1) << 14)) >>> 15;
		if (v > 32767) begin
			v = 32767;
		end
		return MAG_W'(v);
	endfunction

	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		for (int k = 0; k < QTR_N; k++) begin
			tab[k] = sine_mag(k);
		end
		return tab;
	endfunction

	function automatic logic [WT_W-1:0] weight_q16(int d);
		int m;
		longint unsigned t;
		longint c;
		m = SUB_ORDER - 2 * d;
		while (m < 0) begin
			m = m + N4;
		end
		while (m >= N4) begin
			m = m - N4;
		end
		t = (longint'(m) << TURN_BITS) / N4;
		c = sine_q30(t);
		return WT_W'(((longint'(1) << 30) + c + (longint'(1) << 13)) >>> 14);
	endfunction

	function automatic wt_tab_t build_wt();
		wt_tab_t tab;
		for (int j = 0; j < GRID; j++) begin
			tab[j] = weight_q16(j - (SUB_ORDER - 1));
		end
		return tab;
	endfunction

	function automatic off_tab_t build_off();
		off_tab_t tab;
		int a;
		int q;
		for (int j = 0; j < GRID; j++) begin
			a = (j >= SUB_ORDER - 1) ? j - (SUB_ORDER - 1) : (SUB_ORDER - 1) - j;
			q = (20 * a + SUB_ORDER) / (2 * SUB_ORDER);
			tab[j] = (j >= SUB_ORDER - 1) ? OFF_W'(q) : OFF_W'(-q);
		end
		return tab;
	endfunction

	function automatic logic [SUMW_W-1:0] build_sum_w();
		longint s;
		s = 0;
		for (int j = 0; j < GRID; j++) begin
			s = s + longint'(weight_q16(j - (SUB_ORDER - 1)));
		end
		return SUMW_W'(s * s);
	endfunction

	localparam sine_tab_t SINE_MAG = build_sine();
	localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QTR_N);
	localparam wt_tab_t WT = build_wt();
	localparam off_tab_t OFF = build_off();
	localparam logic [SUMW_W-1:0] SUM_W = build_sum_w();
	localparam logic [31:0] RECIP = 32'((longint'(1) << DIV_W) / longint'(SUM_W));

endpackage

// ===== rtl/core/zpg_front.sv =====
// ----------------------------------------------------------------------------
// zpg_front
// Turns a pixel request into centered coordinates in tenths of a pixel and
// holds it in a short queue for the sample engine.
// ----------------------------------------------------------------------------
module zpg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [11:0]         column,
	input  logic [11:0]         row,
	input  logic [12:0]         width,
	input  logic [12:0]         height,
	output zpg_pkg::pix_t       head,
	output logic                head_vld,
	input  logic                head_take
);

	localparam int CNT_W = $clog2(zpg_pkg::IN_DEPTH + 1);
	localparam int PTR_W = $clog2(zpg_pkg::IN_DEPTH);

	zpg_pkg::pix_t            q_q [zpg_pkg::IN_DEPTH];
	logic [CNT_W-1:0]         cnt_q;
	logic [PTR_W-1:0]         wr_q;
	logic [PTR_W-1:0]         rd_q;
	logic [12:0]              w_sat;
	logic [12:0]              h_sat;
	zpg_pkg::pix_t            pix;
	logic                     wr_en;
	logic                     rd_en;

	always_comb begin
		w_sat = (width > 13'(zpg_pkg::MAX_SIDE)) ? 13'(zpg_pkg::MAX_SIDE) : width;
		h_sat = (height > 13'(zpg_pkg::MAX_SIDE)) ? 13'(zpg_pkg::MAX_SIDE) : height;
		pix.cx = zpg_pkg::COORD_W'(column) * zpg_pkg::COORD_W'(10) + zpg_pkg::COORD_W'(5)
			- zpg_pkg::COORD_W'(w_sat) * zpg_pkg::COORD_W'(5);
		pix.cy = zpg_pkg::COORD_W'(row) * zpg_pkg::COORD_W'(10) + zpg_pkg::COORD_W'(5)
			- zpg_pkg::COORD_W'(h_sat) * zpg_pkg::COORD_W'(5);
	end

	assign full     = (cnt_q == CNT_W'(zpg_pkg::IN_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = q_q[rd_q];
	assign wr_en    = push && !full;
	assign rd_en    = head_take && head_vld;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
		end
	end

endmodule

// ===== rtl/core/zpg_sampler.sv =====
// ----------------------------------------------------------------------------
// zpg_sampler
// Walks the subsample grid of one pixel per pass, one subsample a cycle,
// through a pipeline of radius, phase, sine lookup and weighting, and
// accumulates the weighted sine sum.
// ----------------------------------------------------------------------------
module zpg_sampler (
	input  logic                clk,
	input  logic                arst_n,
	input  zpg_pkg::pix_t       head,
	input  logic                head_vld,
	output logic                head_take,
	input  logic [31:0]         phase_step,
	input  logic                out_pop,
	output zpg_pkg::acc_t       acc
);

	localparam int GW = zpg_pkg::GRID_W;
	localparam int CW = zpg_pkg::COORD_W;

	logic                     busy_q;
	logic [GW-1:0]            i_q;
	logic [GW-1:0]            j_q;
	logic signed [CW-1:0]     cx_q;
	logic signed [CW-1:0]     cy_q;
	logic [zpg_pkg::OUT_CNT_W-1:0] out_cnt_q;
	logic                     at_last;
	logic                     start;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                     first_s1, first_s2, first_s3, first_s4, first_s5, first_s6,
		first_s7;
	logic                     last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic [GW-1:0]            jw_s1, jw_s2, jw_s3, jw_s4, jw_s5;
	logic [GW-1:0]            iw_s1, iw_s2, iw_s3, iw_s4, iw_s5, iw_s6;
	logic signed [CW-1:0]     zx_s1, zy_s1;
	logic [31:0]              sqx_s2, sqy_s2;
	logic [31:0]              r2_s3;
	logic [zpg_pkg::TURN_BITS-1:0] frac_s4;
	logic signed [zpg_pkg::F_W-1:0] f_s5;
	logic signed [zpg_pkg::FW1_W-1:0] fw1_s6;
	logic signed [zpg_pkg::FW_W-1:0] fw_s7;
	logic signed [zpg_pkg::ACC_W-1:0] acc_q;
	logic                     done_q;

	logic signed [2*CW-1:0]   sqx;
	logic signed [2*CW-1:0]   sqy;
	logic [63:0]              prod;
	logic [zpg_pkg::TURN_BITS-1:0] frac_rnd;
	logic [zpg_pkg::SINE_BITS-1:0] idx;
	logic [zpg_pkg::QTR_W-1:0] r_idx;
	logic [zpg_pkg::MAG_W-1:0] mag;

	assign at_last   = (i_q == GW'(zpg_pkg::GRID - 1)) && (j_q == GW'(zpg_pkg::GRID - 1));
	assign start     = head_vld && (out_cnt_q < zpg_pkg::OUT_CNT_W'(zpg_pkg::OUT_DEPTH))
		&& (!busy_q || at_last);
	assign head_take = start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			out_cnt_q <= '0;
		end else begin
			out_cnt_q <= out_cnt_q + zpg_pkg::OUT_CNT_W'(start)
				- zpg_pkg::OUT_CNT_W'(out_pop);
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else if (j_q == GW'(zpg_pkg::GRID - 1)) begin
					j_q <= '0;
					i_q <= i_q + GW'(1);
				end else begin
					j_q <= j_q + GW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= head.cx;
			cy_q <= head.cy;
		end
	end

	always_comb begin
		sqx      = zx_s1 * zx_s1;
		sqy      = zy_s1 * zy_s1;
		prod     = 64'(r2_s3) * 64'(phase_step);
		frac_rnd = frac_s4 + (zpg_pkg::TURN_BITS'(1) << (zpg_pkg::TURN_BITS - 1
			- zpg_pkg::SINE_BITS));
		idx      = frac_rnd[zpg_pkg::TURN_BITS-1 -: zpg_pkg::SINE_BITS];
		r_idx    = idx[zpg_pkg::QTR_W-1:0];
		if (idx[zpg_pkg::QTR_W]) begin
			mag = (r_idx == '0) ? zpg_pkg::SINE_PEAK : zpg_pkg::SINE_MAG[~r_idx + 1'b1];
		end else begin
			mag = zpg_pkg::SINE_MAG[r_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done_q <= vld_s7 && last_s7;
		end
	end

	always_ff @(posedge clk) begin
		zx_s1    <= cx_q + CW'(signed'(zpg_pkg::OFF[j_q]));
		zy_s1    <= cy_q + CW'(signed'(zpg_pkg::OFF[i_q]));
		first_s1 <= (i_q == '0) && (j_q == '0);
		last_s1  <= at_last;
		jw_s1    <= j_q;
		iw_s1    <= i_q;

		sqx_s2   <= sqx[31:0];
		sqy_s2   <= sqy[31:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		jw_s2    <= jw_s1;
		iw_s2    <= iw_s1;

		r2_s3    <= sqx_s2 + sqy_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		jw_s3    <= jw_s2;
		iw_s3    <= iw_s2;

		frac_s4  <= prod[zpg_pkg::TURN_BITS-1:0];
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		jw_s4    <= jw_s3;
		iw_s4    <= iw_s3;

		f_s5     <= idx[zpg_pkg::SINE_BITS-1] ? -zpg_pkg::F_W'(mag) : zpg_pkg::F_W'(mag);
		first_s5 <= first_s4;
		last_s5  <= last_s4;
		jw_s5    <= jw_s4;
		iw_s5    <= iw_s4;

		fw1_s6   <= zpg_pkg::FW1_W'(f_s5 * $signed({1'b0, zpg_pkg::WT[jw_s5]}));
		first_s6 <= first_s5;
		last_s6  <= last_s5;
		iw_s6    <= iw_s5;

		fw_s7    <= zpg_pkg::FW_W'(fw1_s6 * $signed({1'b0, zpg_pkg::WT[iw_s6]}));
		first_s7 <= first_s6;
		last_s7  <= last_s6;

		if (vld_s7) begin
			acc_q <= first_s7 ? zpg_pkg::ACC_W'(fw_s7) : acc_q + zpg_pkg::ACC_W'(fw_s7);
		end
	end

	assign acc.vld = done_q;
	assign acc.sum = acc_q;

endmodule

// ===== rtl/core/zpg_finish.sv =====
// ----------------------------------------------------------------------------
// zpg_finish
// Divides the weighted sum by the constant weight total, scales the average
// to the gray range and queues the result.
// ----------------------------------------------------------------------------
module zpg_finish (
	input  logic                clk,
	input  logic                arst_n,
	input  zpg_pkg::acc_t       acc,
	input  logic [15:0]         max_gray,
	input  logic                pop,
	output logic                empty,
	output logic [15:0]         gray_value
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EST   = 7'b0000010,
		ST_REM   = 7'b0000100,
		ST_FIX   = 7'b0001000,
		ST_MUL1  = 7'b0010000,
		ST_MUL2  = 7'b0100000,
		ST_WRITE = 7'b1000000
	} fin_state_t;

	localparam int DW = zpg_pkg::DIV_W;
	localparam int PW = zpg_pkg::OUT_PTR_W;

	fin_state_t               state_q;
	logic [DW-1:0]            rem_q;
	logic [zpg_pkg::Q_W-1:0]  quo_q;
	logic                     neg_q;
	logic [31:0]              p1_q;
	logic [63:0]              p2_q;
	logic [15:0]              fifo_q [zpg_pkg::OUT_DEPTH];
	logic [PW-1:0]            wr_q;
	logic [PW-1:0]            rd_q;
	logic [zpg_pkg::OUT_CNT_W-1:0] cnt_q;

	logic [zpg_pkg::ACC_W-1:0] mag;
	logic [63:0]               est;
	logic [zpg_pkg::Q_W-1:0]   qc;
	logic [15:0]               pv;
	logic [15:0]               mm;
	logic [63:0]               p2_rnd;
	logic                      wr_en;
	logic                      rd_en;

	always_comb begin
		mag    = acc.sum[zpg_pkg::ACC_W-1] ? zpg_pkg::ACC_W'(-acc.sum)
			: zpg_pkg::ACC_W'(acc.sum);
		est    = 64'(rem_q[DW-1 -: 32]) * 64'(zpg_pkg::RECIP);
		qc     = (quo_q > zpg_pkg::Q_W'(32767)) ? zpg_pkg::Q_W'(32767) : quo_q;
		pv     = neg_q ? 16'(16'd32768 - qc) : 16'(16'd32768 + qc);
		mm     = (max_gray >= 16'd1) ? max_gray - 16'd1 : 16'd0;
		p2_rnd = p2_q + (64'd1 << 47);
	end

	assign wr_en      = (state_q == ST_WRITE);
	assign empty      = (cnt_q == '0);
	assign rd_en      = pop && !empty;
	assign gray_value = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc.vld) begin
						state_q <= ST_EST;
					end
				end
				ST_EST: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wr_en) begin
				wr_q <= wr_q + PW'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + zpg_pkg::OUT_CNT_W'(wr_en) - zpg_pkg::OUT_CNT_W'(rd_en);
		end
	end

	// The reciprocal estimate is low by at most two; the correction step adds that back.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc.vld) begin
			rem_q <= DW'(mag) + DW'(zpg_pkg::SUM_W >> 1);
			neg_q <= acc.sum[zpg_pkg::ACC_W-1];
		end
		if (state_q == ST_EST) begin
			quo_q <= est[32 +: zpg_pkg::Q_W];
		end
		if (state_q == ST_REM) begin
			rem_q <= rem_q - DW'(quo_q) * DW'(zpg_pkg::SUM_W);
		end
		if (state_q == ST_FIX) begin
			if (rem_q >= (DW'(zpg_pkg::SUM_W) << 1)) begin
				quo_q <= quo_q + zpg_pkg::Q_W'(2);
			end else if (rem_q >= DW'(zpg_pkg::SUM_W)) begin
				quo_q <= quo_q + zpg_pkg::Q_W'(1);
			end
		end
		if (state_q == ST_MUL1) begin
			p1_q <= 32'(mm) * 32'(pv);
		end
		if (state_q == ST_MUL2) begin
			p2_q <= 64'(zpg_pkg::HALF_SCALE_Q32) * 64'(p1_q);
		end
		if (wr_en) begin
			fifo_q[wr_q] <= 16'(16'd1 + p2_rnd[63:48]);
		end
	end

endmodule

// ===== rtl/core/zone_plate_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// zone_plate_pixel_generator_unit
// Antialiased zone-plate test pattern, one gray value per pixel request.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  request   push / full                column[11:0], row[11:0]
//  result    empty / pop                gray_value[15:0]
//  config    cfg_valid / cfg_ready      cfg_index[1:0], cfg_data[31:0]
//
//  A pixel passes the sample pipeline one subsample per cycle; the next pixel
//  can start as the last subsample of the one before issues, so pixels follow
//  without a gap while the output queue has room. A request is registered in
//  the input queue, then in the grid counters; each subsample passes stages s1
//  to s7 into the sum, and the finish runs reciprocal estimate, remainder,
//  correction, the multiplies to the gray range and queue write. Up to four
//  results wait in the output queue; when it fills, the sample engine stops at a pixel boundary.
//  Reset loads 512x512, max_gray 65535 and the matching phase step.
module zone_plate_pixel_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] column,
	input  logic [11:0] row,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] gray_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic [15:0]        max_gray_q;
	logic [31:0]        phase_step_q;
	zpg_pkg::pix_t      head;
	logic               head_vld;
	logic               head_take;
	zpg_pkg::acc_t      acc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= 13'd512;
			height_q     <= 13'd512;
			max_gray_q   <= 16'd65535;
			phase_step_q <= 32'd4833583;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				zpg_pkg::REG_WIDTH:      width_q      <= cfg_data[12:0];
				zpg_pkg::REG_HEIGHT:     height_q     <= cfg_data[12:0];
				zpg_pkg::REG_MAX_GRAY:   max_gray_q   <= cfg_data[15:0];
				zpg_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	zpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.column    (column),
		.row       (row),
		.width     (width_q),
		.height    (height_q),
		.head      (head),
		.head_vld  (head_vld),
		.head_take (head_take)
	);

	zpg_sampler u_sampler (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_vld   (head_vld),
		.head_take  (head_take),
		.phase_step (phase_step_q),
		.out_pop    (pop && !empty),
		.acc        (acc)
	);

	zpg_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.max_gray   (max_gray_q),
		.pop        (pop),
		.empty      (empty),
		.gray_value (gray_value)
	);

endmodule

// ===== rtl/core/zpg_checker.sv =====
// ----------------------------------------------------------------------------
// zpg_checker
// Port-level checks of the zone-plate generator: results match requests in
// count and stay in range.
// ----------------------------------------------------------------------------
module zpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [15:0] gray_value
);

	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result shown without an outstanding request");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 4'd0 |-> empty)
		else $error("result queue not empty with nothing outstanding");

	a_gray_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> gray_value != 16'd0)
		else $error("gray value below one");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(gray_value))
		else $error("waiting result changed or vanished");

endmodule

bind zone_plate_pixel_generator_unit zpg_checker u_zpg_checker (.*);
